// ----- sv/bea_pkg.sv -----
// Shared types and constants for the bitmap entry allocator.
`default_nettype none

package bea_pkg;

    localparam int POOL_ENTRIES_DEF = 1024;
    localparam int WORD_BITS_DEF    = 32;

    localparam int PTR_W    = 11;
    localparam int IDX_W    = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 11'd1024;
    localparam logic [CFG_W-1:0] RESERVED_RST  = 11'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_SIZE = 1'b0,
        CFG_RESERVED  = 1'b1
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_TEST   = 2'd2,
        OP_FORMAT = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_RANGE        = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic chk;
        logic div;
        logic rd;
        logic modify;
        logic scan;
        logic clr;
        logic clr_zero;
        logic fin;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic reject;
        logic scan_done;
        logic clr_done;
    } sts_t;

endpackage

`default_nettype wire

// ----- sv/bea_ctrl.sv -----
// Sequencing state machine of the bitmap entry allocator.
`default_nettype none

module bea_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire bea_pkg::sts_t sts,
    output bea_pkg::cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CHECK = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_READ  = 9'b000010000,
        S_MOD   = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_CLEAR = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr      = 1'b1;
                cmd.clr_zero = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.chk = 1'b1;
                if (sts.op == bea_pkg::OP_FORMAT)
                begin
                    state_next = S_CLEAR;
                end
                else if (sts.reject)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.modify = 1'b1;
                if (sts.op == bea_pkg::OP_ALLOC && !sts.scan_done)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- sv/bea_dp.sv -----
// Datapath of the bitmap entry allocator: bitmap memory, pointer, count and result registers.
`default_nettype none

module bea_dp #(
    parameter int POOL_ENTRIES = bea_pkg::POOL_ENTRIES_DEF,
    parameter int WORD_BITS    = bea_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bea_pkg::cmd_t                 cmd,
    output bea_pkg::sts_t                      sts,
    input  wire logic [bea_pkg::OP_W-1:0]      in_op,
    input  wire logic [bea_pkg::IDX_W-1:0]     in_index,
    input  wire logic                          cfg_we,
    input  wire logic [bea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bea_pkg::CFG_W-1:0]     cfg_data,
    output logic [bea_pkg::PTR_W-1:0]          out_granted,
    output logic [bea_pkg::STATUS_W-1:0]       out_status,
    output logic                               out_bit,
    output logic [bea_pkg::PTR_W-1:0]          out_remaining
);

    localparam int PW        = bea_pkg::PTR_W;
    localparam int MAP_DEPTH = (POOL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int SPAN_W    = $clog2(MAP_DEPTH * WORD_BITS + WORD_BITS) + 1;
    localparam int BASE_W    = (SPAN_W > PW + 1) ? SPAN_W : PW + 1;
    localparam int SH        = PW + BW + 1;
    localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RCP_W     = SH + 1;
    localparam int PROD_W    = PW + RCP_W;

    logic [WORD_BITS-1:0] mem [MAP_DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        rd_adr;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WORD_BITS-1:0] mem_wd;

    logic [PW-1:0]  pool_size_reg, pool_size_next;
    logic [PW-1:0]  rsv_reg, rsv_next;
    logic [PW-1:0]  ptr_reg, ptr_next;
    logic [PW-1:0]  free_reg, free_next;
    logic [AW-1:0]  clr_adr_reg, clr_adr_next;

    bea_pkg::op_t            op_reg, op_next;
    logic [bea_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [PW-1:0]           num_reg, num_next;
    logic [PW-1:0]           q_reg, q_next;
    logic [BASE_W-1:0]       base_reg, base_next;
    logic [BW-1:0]           bit_reg, bit_next;
    logic [AW-1:0]           scan_adr_reg, scan_adr_next;
    logic [BASE_W-1:0]       clr_base_reg, clr_base_next;
    logic [PW-1:0]           r_reg, r_next;
    logic [PW-1:0]           grant_reg, grant_next;
    bea_pkg::status_t        status_reg, status_next;
    logic                    tbit_reg, tbit_next;
    logic [PW-1:0]           o_grant_reg, o_grant_next;
    logic [bea_pkg::STATUS_W-1:0] o_status_reg, o_status_next;
    logic                    o_bit_reg, o_bit_next;
    logic [PW-1:0]           o_free_reg, o_free_next;

    logic [PW-1:0]        size;
    logic [PW-1:0]        r_clip;
    logic                 reject;
    logic [PROD_W-1:0]    recip_prod;
    logic [BASE_W-1:0]    base_prod;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] above_mask;
    logic [WORD_BITS-1:0] src;
    logic                 found;
    logic [BW-1:0]        enc;
    logic [BASE_W-1:0]    pos;
    logic                 hit;
    logic                 past;
    logic [WORD_BITS-1:0] clr_word;

    function automatic logic [BW:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BW:0] res;
        res = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (v[b])
            begin
                res = {1'b1, BW'(b)};
            end
        end
        return res;
    endfunction

    always_comb
    begin
        if (int'(pool_size_reg) > POOL_ENTRIES)
        begin
            size = PW'(POOL_ENTRIES);
        end
        else
        begin
            size = pool_size_reg;
        end
        r_clip = (rsv_reg > size) ? size : rsv_reg;
        if (op_reg == bea_pkg::OP_ALLOC)
        begin
            reject = (free_reg == '0) || (ptr_reg >= size);
        end
        else
        begin
            reject = (op_reg != bea_pkg::OP_FORMAT) && ({1'b0, idx_reg} >= size);
        end
    end

    assign recip_prod = PROD_W'(num_reg) * PROD_W'(RECIP);
    assign base_prod  = BASE_W'(q_reg) * BASE_W'(WORD_BITS);
    assign bit_mask   = WORD_BITS'(1) << bit_reg;
    assign above_mask = ({WORD_BITS{1'b1}} << bit_reg) << 1;
    assign src        = cmd.modify ? (~(rd_data_reg | bit_mask) & above_mask) : ~rd_data_reg;
    assign {found, enc} = lowest_set(src);
    assign pos        = base_reg + BASE_W'(enc);
    assign hit        = found && (pos < BASE_W'(size));
    assign past       = (base_reg + BASE_W'(WORD_BITS)) >= BASE_W'(size);

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            clr_word[b] = !cmd.clr_zero && ((clr_base_reg + BASE_W'(b)) < BASE_W'(r_reg));
        end
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.reject    = reject;
        sts.scan_done = hit || past;
        sts.clr_done  = (clr_adr_reg == AW'(MAP_DEPTH - 1));
    end

    always_comb
    begin
        pool_size_next = pool_size_reg;
        rsv_next       = rsv_reg;
        ptr_next       = ptr_reg;
        free_next      = free_reg;
        clr_adr_next   = clr_adr_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        q_next         = q_reg;
        base_next      = base_reg;
        bit_next       = bit_reg;
        scan_adr_next  = scan_adr_reg;
        clr_base_next  = clr_base_reg;
        r_next         = r_reg;
        grant_next     = grant_reg;
        status_next    = status_reg;
        tbit_next      = tbit_reg;
        o_grant_next   = o_grant_reg;
        o_status_next  = o_status_reg;
        o_bit_next     = o_bit_reg;
        o_free_next    = o_free_reg;
        rd_adr         = scan_adr_reg;
        mem_we         = 1'b0;
        mem_wa         = AW'(q_reg);
        mem_wd         = rd_data_reg;

        if (cfg_we)
        begin
            case (bea_pkg::cfg_idx_t'(cfg_index))
                bea_pkg::CFG_POOL_SIZE: pool_size_next = cfg_data;
                bea_pkg::CFG_RESERVED:  rsv_next       = cfg_data;
                default:                pool_size_next = pool_size_reg;
            endcase
        end

        if (cmd.load)
        begin
            op_next     = bea_pkg::op_t'(in_op);
            idx_next    = in_index;
            num_next    = (bea_pkg::op_t'(in_op) == bea_pkg::OP_ALLOC) ? ptr_reg
                                                                     : {1'b0, in_index};
            grant_next  = '0;
            status_next = bea_pkg::ST_OK;
            tbit_next   = 1'b0;
        end

        if (cmd.chk)
        begin
            q_next = PW'(recip_prod >> SH);
            if (op_reg == bea_pkg::OP_FORMAT)
            begin
                r_next        = r_clip;
                free_next     = size - r_clip;
                ptr_next      = r_clip;
                clr_adr_next  = '0;
                clr_base_next = '0;
            end
            else if (reject)
            begin
                status_next = (op_reg == bea_pkg::OP_ALLOC) ? bea_pkg::ST_FULL
                                                            : bea_pkg::ST_RANGE;
            end
        end

        if (cmd.div)
        begin
            base_next = base_prod;
            bit_next  = BW'(BASE_W'(num_reg) - base_prod);
        end

        if (cmd.rd)
        begin
            rd_adr        = AW'(q_reg);
            scan_adr_next = AW'(q_reg) + AW'(1);
        end

        if (cmd.modify || cmd.scan)
        begin
            scan_adr_next = scan_adr_reg + AW'(1);
        end

        if (cmd.modify)
        begin
            case (op_reg)
                bea_pkg::OP_TEST:
                begin
                    tbit_next = |(rd_data_reg & bit_mask);
                end
                bea_pkg::OP_FREE:
                begin
                    if (!(|(rd_data_reg & bit_mask)))
                    begin
                        status_next = bea_pkg::ST_ALREADY_FREE;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wd = rd_data_reg & ~bit_mask;
                        if (free_reg < size)
                        begin
                            free_next = free_reg + PW'(1);
                        end
                        if ({1'b0, idx_reg} < ptr_reg)
                        begin
                            ptr_next = {1'b0, idx_reg};
                        end
                    end
                end
                bea_pkg::OP_ALLOC:
                begin
                    mem_we     = 1'b1;
                    mem_wd     = rd_data_reg | bit_mask;
                    grant_next = ptr_reg;
                    free_next  = free_reg - PW'(1);
                end
                default:
                begin
                    tbit_next = tbit_reg;
                end
            endcase
        end

        if ((cmd.modify && op_reg == bea_pkg::OP_ALLOC) || cmd.scan)
        begin
            if (hit)
            begin
                ptr_next = PW'(pos);
            end
            else if (past)
            begin
                ptr_next = size;
            end
            else
            begin
                base_next = base_reg + BASE_W'(WORD_BITS);
            end
        end

        if (cmd.clr)
        begin
            mem_we        = 1'b1;
            mem_wa        = clr_adr_reg;
            mem_wd        = clr_word;
            clr_adr_next  = clr_adr_reg + AW'(1);
            clr_base_next = clr_base_reg + BASE_W'(WORD_BITS);
        end

        if (cmd.fin)
        begin
            o_grant_next  = grant_reg;
            o_status_next = status_reg;
            o_bit_next    = tbit_reg;
            o_free_next   = free_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_adr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= bea_pkg::POOL_SIZE_RST;
            rsv_reg       <= bea_pkg::RESERVED_RST;
            ptr_reg       <= '0;
            free_reg      <= '0;
            clr_adr_reg   <= '0;
        end
        else
        begin
            pool_size_reg <= pool_size_next;
            rsv_reg       <= rsv_next;
            ptr_reg       <= ptr_next;
            free_reg      <= free_next;
            clr_adr_reg   <= clr_adr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        num_reg      <= num_next;
        q_reg        <= q_next;
        base_reg     <= base_next;
        bit_reg      <= bit_next;
        scan_adr_reg <= scan_adr_next;
        clr_base_reg <= clr_base_next;
        r_reg        <= r_next;
        grant_reg    <= grant_next;
        status_reg   <= status_next;
        tbit_reg     <= tbit_next;
        o_grant_reg  <= o_grant_next;
        o_status_reg <= o_status_next;
        o_bit_reg    <= o_bit_next;
        o_free_reg   <= o_free_next;
    end

    assign out_granted   = o_grant_reg;
    assign out_status    = o_status_reg;
    assign out_bit       = o_bit_reg;
    assign out_remaining = o_free_reg;

endmodule

`default_nettype wire

// ----- sv/bitmap_entry_allocator.sv -----
// Top level of the bitmap entry allocator: stream ports, controller and datapath.
//
//   channel   direction  payload
//   s_*       in         tuser: op; tdata: entry_index
//   m_*       out        tdata: granted_index, status, bit_is_set, remaining_free
//   cfg_*     in         register index, write data (0 pool_size, 1 reserved_count)
//
// From the accepting edge to m_tvalid: a rejected beat passes CHECK and FIN; free and test
// pass CHECK, DIV, READ, MOD and FIN. Allocate adds SCAN after MOD, stepping through the
// bitmap words past the granted entry's word; the single bitmap read port sets the pace.
// Format writes every bitmap word once, in CLEAR between CHECK and FIN.
// After reset a clearing pass writes every bitmap word to zero before s_tready.
// s_tready returns once the result is loaded; a result waits there while the next beat runs.
`default_nettype none

module bitmap_entry_allocator #(
    parameter int POOL_ENTRIES = bea_pkg::POOL_ENTRIES_DEF,
    parameter int WORD_BITS    = bea_pkg::WORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bea_pkg::S_TDATA_W-1:0]     s_tdata,   // [9:0] entry_index
    input  wire logic [bea_pkg::S_TUSER_W-1:0]     s_tuser,   // [1:0] op
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bea_pkg::M_TDATA_W-1:0]          m_tdata,   // [10:0] granted_index,
                                                              // [12:11] status,
                                                              // [13] bit_is_set,
                                                              // [24:14] remaining_free
    input  wire logic                              cfg_we,
    input  wire logic [bea_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bea_pkg::CFG_W-1:0]         cfg_data
);

    localparam int RES_W = 2 * bea_pkg::PTR_W + bea_pkg::STATUS_W + 1;

    bea_pkg::cmd_t cmd;
    bea_pkg::sts_t sts;

    logic [bea_pkg::PTR_W-1:0]    granted;
    logic [bea_pkg::STATUS_W-1:0] status;
    logic                         bit_set;
    logic [bea_pkg::PTR_W-1:0]    remaining;

    bea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bea_dp #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .WORD_BITS    (WORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (s_tuser),
        .in_index      (s_tdata[bea_pkg::IDX_W-1:0]),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_granted   (granted),
        .out_status    (status),
        .out_bit       (bit_set),
        .out_remaining (remaining)
    );

    assign m_tdata = {{(bea_pkg::M_TDATA_W - RES_W){1'b0}}, remaining, bit_set, status, granted};

endmodule

`default_nettype wire
